/* rtl/jsfe_pkg.sv */
// Shared types and constants of the JSON string field extractor.
// No dependencies; every other file except jsfe_chan_if refers to it by scoped names.
package jsfe_pkg;

  localparam int KEY_BITS = 128;  // two 64-bit key registers, 16 characters
  localparam int CFG_BITS = 64;
  localparam int Q_DEPTH  = 4;    // result queue, power of two

  typedef enum logic [1:0] {
    CFG_KEY_LOW  = 2'd0,
    CFG_KEY_HIGH = 2'd1,
    CFG_KEY_LEN  = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    PH_SEARCH,
    PH_SKIP,
    PH_STRING,
    PH_ESCAPE,
    PH_DONE
  } phase_t;

  localparam logic [1:0] ST_FOUND      = 2'd0;
  localparam logic [1:0] ST_ABSENT     = 2'd1;
  localparam logic [1:0] ST_NOT_STRING = 2'd2;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;

  typedef struct packed {
    logic [7:0] line_byte;
    logic       line_end;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] value_byte;
    logic       done_res;
    logic [1:0] status;
  } out_beat_t;

  // per-cell compare result
  typedef struct packed {
    logic ok;
    logic end_quote;
  } cell_flags_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } win_ctl_t;

  // results caused by one input beat: value byte first, then final result
  typedef struct packed {
    logic       val_valid;
    logic [7:0] val_byte;
    logic       done_valid;
    logic [1:0] done_status;
  } push_req_t;

endpackage

/* rtl/jsfe_chan_if.sv */
// Valid/ready channel carrying one payload struct per beat.
// Payload type comes from jsfe_pkg at the point of instantiation.
interface jsfe_chan_if #(
  parameter type payload_t = logic [7:0]
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/json_string_field_extractor.sv */
// Top level of the JSON string field extractor: config registers, window
// cell chain, phase sequencer and result queue. Needs jsfe_pkg, jsfe_chan_if.
//
//   port       dir   beat payload                        meaning
//   in_chan    sink  line_byte[7:0], line_end            one text byte
//   out_chan   src   value_byte[7:0], done_res, status   value byte / final
//   cfg_*      in    cfg_we, cfg_index[1:0], cfg_wdata   key registers
//
// A new byte is taken every cycle while the four-entry result queue has
// room for two results (in_chan.ready low when it holds three or more).
// Results are written into the queue when their byte is taken.
// Output stalls back up through the queue only. Reset (rst_n low, sync)
// clears window, phase, queue and config registers to their defaults.
module json_string_field_extractor #(
  parameter int MAX_KEY_CHARS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  jsfe_chan_if.sink                       in_chan,
  jsfe_chan_if.source                     out_chan,
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_index,
  input  logic [jsfe_pkg::CFG_BITS-1:0]   cfg_wdata
);

  // the newest window byte is compared straight from the input, so it is not stored
  localparam int NUM_CELLS = MAX_KEY_CHARS + 1;

  logic [jsfe_pkg::CFG_BITS-1:0] key_low_r, key_high_r;
  logic [4:0]                    key_len_r;
  logic [4:0]                    len_sat;
  logic                          accept;
  logic                          room;
  logic                          match;
  jsfe_pkg::in_beat_t            beat;
  jsfe_pkg::win_ctl_t            win_ctl;
  jsfe_pkg::push_req_t           push;
  jsfe_pkg::cell_flags_t         flags [NUM_CELLS];
  logic [7:0]                    chain [NUM_CELLS+1];
  logic [NUM_CELLS-1:0]          ok_vec, endq_vec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r  <= '0;
      key_high_r <= '0;
      key_len_r  <= 5'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        jsfe_pkg::CFG_KEY_LOW:  key_low_r  <= cfg_wdata;
        jsfe_pkg::CFG_KEY_HIGH: key_high_r <= cfg_wdata;
        jsfe_pkg::CFG_KEY_LEN:  key_len_r  <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  assign len_sat = (key_len_r > 5'(MAX_KEY_CHARS)) ? 5'(MAX_KEY_CHARS) : key_len_r;

  assign beat          = in_chan.data;
  assign in_chan.ready = room;
  assign accept        = in_chan.valid && room;
  assign chain[0]      = beat.line_byte;

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    jsfe_win_cell #(
      .CELL_IDX (k)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (win_ctl),
      .din   (chain[k]),
      .key   ({key_high_r, key_low_r}),
      .len   (len_sat),
      .dout  (chain[k+1]),
      .flags (flags[k])
    );
    assign ok_vec[k]   = flags[k].ok;
    assign endq_vec[k] = flags[k].end_quote;
  end

  // new byte is the closing quote; key bytes and opening quote sit behind it
  assign match = (beat.line_byte == jsfe_pkg::CH_QUOTE) && (&ok_vec) && (|endq_vec);

  jsfe_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .beat    (beat),
    .match   (match),
    .win_ctl (win_ctl),
    .push    (push)
  );

  jsfe_out_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .room     (room),
    .out_chan (out_chan)
  );

endmodule

/* rtl/jsfe_win_cell.sv */
// One byte of the key match window: holds a byte, passes it on each shift, clears
// on ctl.clear, and compares it with the key character for its position and with a quote.
module jsfe_win_cell #(
  parameter int CELL_IDX = 0
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  jsfe_pkg::win_ctl_t           ctl,
  input  logic [7:0]                   din,
  input  logic [jsfe_pkg::KEY_BITS-1:0] key,
  input  logic [4:0]                   len,
  output logic [7:0]                   dout,
  output jsfe_pkg::cell_flags_t        flags
);

  logic [7:0] byte_r;
  logic [4:0] key_idx;
  logic       in_range;
  logic [7:0] key_char;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r <= 8'd0;
    end else if (ctl.clear) begin
      byte_r <= 8'd0;
    end else if (ctl.shift) begin
      byte_r <= din;
    end
  end

  // After the shift this byte sits at position CELL_IDX+1, which must hold
  // key character len-1-CELL_IDX when that position lies inside the key.
  always_comb begin
    key_idx   = len - 5'(CELL_IDX) - 5'd1;
    in_range  = 5'(CELL_IDX) < len;
    key_char  = key[{key_idx[3:0], 3'b000} +: 8];
    flags.ok  = !in_range || (byte_r == key_char);
    flags.end_quote = (len == 5'(CELL_IDX)) && (byte_r == jsfe_pkg::CH_QUOTE);
  end

  assign dout = byte_r;

endmodule

/* rtl/jsfe_ctrl.sv */
// Phase sequencer: key found, skip separators, decode string, report status.
// Uses jsfe_pkg types; drives window shift/clear and the result queue pushes.
module jsfe_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  jsfe_pkg::in_beat_t  beat,
  input  logic                match,
  output jsfe_pkg::win_ctl_t  win_ctl,
  output jsfe_pkg::push_req_t push
);

  jsfe_pkg::phase_t phase_r, phase_nxt, ph_after;
  logic             is_sep;
  logic             proc_done;
  logic [1:0]       proc_st;

  function automatic logic [7:0] decode_escape(input logic [7:0] c);
    logic [7:0] r;
    unique case (c)
      jsfe_pkg::CH_N: r = jsfe_pkg::CH_LF;
      jsfe_pkg::CH_T: r = jsfe_pkg::CH_TAB;
      jsfe_pkg::CH_R: r = jsfe_pkg::CH_CR;
      jsfe_pkg::CH_B: r = jsfe_pkg::CH_BS;
      jsfe_pkg::CH_F: r = jsfe_pkg::CH_FF;
      default:        r = c;
    endcase
    return r;
  endfunction

  assign is_sep = (beat.line_byte == jsfe_pkg::CH_SPACE) ||
                  (beat.line_byte == jsfe_pkg::CH_TAB) ||
                  (beat.line_byte == jsfe_pkg::CH_COLON);

  // next state
  always_comb begin
    ph_after = phase_r;
    unique case (phase_r)
      jsfe_pkg::PH_SEARCH: begin
        if (match) ph_after = jsfe_pkg::PH_SKIP;
      end
      jsfe_pkg::PH_SKIP: begin
        if (beat.line_byte == jsfe_pkg::CH_QUOTE) ph_after = jsfe_pkg::PH_STRING;
        else if (!is_sep) ph_after = jsfe_pkg::PH_DONE;
      end
      jsfe_pkg::PH_STRING: begin
        if (beat.line_byte == jsfe_pkg::CH_QUOTE) begin
          ph_after = jsfe_pkg::PH_DONE;
        end else if (beat.line_byte == jsfe_pkg::CH_BSLASH && !beat.line_end) begin
          ph_after = jsfe_pkg::PH_ESCAPE;
        end
      end
      jsfe_pkg::PH_ESCAPE: ph_after = jsfe_pkg::PH_STRING;
      default:             ph_after = phase_r;
    endcase
    phase_nxt = phase_r;
    if (accept) phase_nxt = beat.line_end ? jsfe_pkg::PH_SEARCH : ph_after;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= jsfe_pkg::PH_SEARCH;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  // outputs
  always_comb begin
    push          = '0;
    push.val_byte = beat.line_byte;
    proc_done     = 1'b0;
    proc_st       = jsfe_pkg::ST_FOUND;
    unique case (phase_r)
      jsfe_pkg::PH_SKIP: begin
        if (!is_sep && beat.line_byte != jsfe_pkg::CH_QUOTE) begin
          proc_done = 1'b1;
          proc_st   = jsfe_pkg::ST_NOT_STRING;
        end
      end
      jsfe_pkg::PH_STRING: begin
        if (beat.line_byte == jsfe_pkg::CH_QUOTE) begin
          proc_done = 1'b1;
        end else if (!(beat.line_byte == jsfe_pkg::CH_BSLASH && !beat.line_end)) begin
          push.val_valid = 1'b1;
        end
      end
      jsfe_pkg::PH_ESCAPE: begin
        push.val_valid = 1'b1;
        push.val_byte  = decode_escape(beat.line_byte);
      end
      default: ;
    endcase
    push.val_valid  = push.val_valid && accept;
    push.done_valid = accept &&
                      (proc_done || (beat.line_end && ph_after != jsfe_pkg::PH_DONE));
    if (proc_done) begin
      push.done_status = proc_st;
    end else if (ph_after == jsfe_pkg::PH_SEARCH) begin
      push.done_status = jsfe_pkg::ST_ABSENT;
    end else if (ph_after == jsfe_pkg::PH_SKIP) begin
      push.done_status = jsfe_pkg::ST_NOT_STRING;
    end else begin
      push.done_status = jsfe_pkg::ST_FOUND;
    end
    win_ctl.shift = accept && (phase_r == jsfe_pkg::PH_SEARCH);
    win_ctl.clear = accept && beat.line_end;
  end

`ifndef SYNTHESIS
  a_line_end_rearms: assert property (@(posedge clk) disable iff (!rst_n)
    accept && beat.line_end |=> phase_r == jsfe_pkg::PH_SEARCH)
    else $error("phase not back to search after line end");

  a_pair_is_found: assert property (@(posedge clk) disable iff (!rst_n)
    push.val_valid && push.done_valid |-> push.done_status == jsfe_pkg::ST_FOUND)
    else $error("value byte paired with non-found status");

  a_quiet_when_done: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == jsfe_pkg::PH_DONE |-> !push.val_valid)
    else $error("value byte after final result");
`endif

endmodule

/* rtl/jsfe_out_fifo.sv */
// Result queue: takes up to two results per cycle, delivers one per beat.
// Uses jsfe_pkg types and the jsfe_chan_if source modport.
module jsfe_out_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  jsfe_pkg::push_req_t push,
  output logic                room,
  jsfe_chan_if.source         out_chan
);

  localparam int PW = $clog2(jsfe_pkg::Q_DEPTH);
  localparam int CW = $clog2(jsfe_pkg::Q_DEPTH + 1);

  jsfe_pkg::out_beat_t mem_r [jsfe_pkg::Q_DEPTH];
  logic [PW-1:0]       wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [1:0]          n_push;
  logic                pop;
  jsfe_pkg::out_beat_t val_beat, done_beat, first_beat;

  always_comb begin
    val_beat   = '{value_byte: push.val_byte, done_res: 1'b0,
                   status: jsfe_pkg::ST_FOUND};
    done_beat  = '{value_byte: 8'd0, done_res: 1'b1, status: push.done_status};
    first_beat = push.val_valid ? val_beat : done_beat;
    n_push     = {1'b0, push.val_valid} + {1'b0, push.done_valid};
    pop        = out_chan.valid && out_chan.ready;
    wr_ptr_nxt = wr_ptr_r + PW'(n_push);
    rd_ptr_nxt = rd_ptr_r + PW'(pop);
    count_nxt  = count_r + CW'(n_push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) mem_r[wr_ptr_r] <= first_beat;
    if (n_push == 2'd2) mem_r[wr_ptr_r + PW'(1)] <= done_beat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // accept a new byte only while two results still fit
  assign room           = count_r <= CW'(jsfe_pkg::Q_DEPTH - 2);
  assign out_chan.valid = count_r != '0;
  assign out_chan.data  = mem_r[rd_ptr_r];

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    n_push != 2'd0 |-> count_r <= CW'(jsfe_pkg::Q_DEPTH - 2))
    else $error("push into full result queue");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(jsfe_pkg::Q_DEPTH))
    else $error("result queue count out of range");
`endif

endmodule
